### hdl/dena_pkg.sv
// ----------------------------------------------------------------------------
// dena_pkg
// Types, constants and helpers shared by the directory entry name assembler.
// ----------------------------------------------------------------------------
package dena_pkg;

    localparam int LFN_CHARS = 13;
    localparam int LFN_OFS [LFN_CHARS] = '{1, 3, 5, 7, 9, 14, 16, 18, 20, 22, 24, 28, 30};
    localparam int SHORT_LEN = 12;

    localparam logic [7:0]  ATTR_LFN_MASK = 8'h3F;
    localparam logic [7:0]  ATTR_LFN      = 8'h0F;
    localparam logic [7:0]  ORDER_FIRST   = 8'h40;
    localparam logic [7:0]  ORDER_SLOT    = 8'h1F;
    localparam logic [7:0]  BYTE_END      = 8'h00;
    localparam logic [7:0]  BYTE_DELETED  = 8'hE5;
    localparam logic [7:0]  BYTE_KANJI    = 8'h05;
    localparam logic [7:0]  CHAR_QMARK    = 8'h3F;
    localparam logic [7:0]  CHAR_SPACE    = 8'h20;
    localparam logic [7:0]  CHAR_DOT      = 8'h2E;
    localparam logic [15:0] CHAR_NONE     = 16'hFFFF;
    localparam logic [15:0] CHAR_NUL      = 16'h0000;
    localparam logic [15:0] ASCII_LIMIT   = 16'h0080;
    localparam int          ATTR_VOL_BIT  = 3;
    localparam int          ATTR_DIR_BIT  = 4;

    localparam logic KIND_NAME = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef struct packed {
        logic       term;
        logic [7:0] ch;
    } t_code;

    typedef t_code [LFN_CHARS-1:0] t_row;

    typedef struct packed {
        logic       en;
        logic       clear;
        logic [4:0] row;
        t_row       data;
    } t_row_wr;

    typedef struct packed {
        logic                      go;
        logic                      end_dir;
        logic                      from_long;
        logic [SHORT_LEN-1:0][7:0] text;
        logic [3:0]                text_len;
        logic [31:0]               cluster;
        logic [31:0]               size;
        logic                      is_dir;
    } t_emit_req;

    function automatic logic [7:0] cks_step(input logic [7:0] s, input logic [7:0] b);
        return {s[0], s[7:1]} + b;
    endfunction

endpackage

### hdl/dena_lane.sv
// ----------------------------------------------------------------------------
// dena_lane
// One character lane: turns a UTF-16 long-name character into a stored code.
// ----------------------------------------------------------------------------
module dena_lane
    import dena_pkg::*;
(
    input  logic [15:0] i_char,
    input  logic        i_beyond,
    output t_code       o_code
);

    always_comb begin
        o_code.term = i_beyond || (i_char == CHAR_NUL) || (i_char == CHAR_NONE);
        o_code.ch   = (i_char < ASCII_LIMIT) ? i_char[7:0] : CHAR_QMARK;
    end

endmodule

### hdl/dena_emit.sv
// ----------------------------------------------------------------------------
// dena_emit
// Name store, lane merge and chunk emitter with the output register.
// ----------------------------------------------------------------------------
module dena_emit
    import dena_pkg::*;
#(
    parameter int MAX_SLOTS        = 20,
    parameter int CHARS_PER_RESULT = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_row_wr     i_wr,
    input  t_emit_req   i_req,
    output logic        o_busy,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_result_kind,
    output logic [63:0] o_name_chars,
    output logic [3:0]  o_char_count,
    output logic        o_from_long_name,
    output logic [31:0] o_first_cluster,
    output logic [31:0] o_file_size,
    output logic        o_is_directory,
    output logic        o_last_of_run
);

    localparam int BUF    = CHARS_PER_RESULT + LFN_CHARS;
    localparam int CNT_W  = $clog2(BUF + 1);
    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

    typedef enum logic [3:0] {
        E_IDLE   = 4'b0001,
        E_READ   = 4'b0010,
        E_APPEND = 4'b0100,
        E_EMIT   = 4'b1000
    } t_estate;

    t_estate r_state, n_state;
    t_row    mem [MAX_SLOTS];
    t_row    r_rd_row;
    logic    r_rd_ok;
    logic [MAX_SLOTS-1:0] r_rows, n_rows;
    logic [7:0] r_buf [BUF];
    logic [7:0] n_buf [BUF];
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic r_done, n_done;
    logic [SLOT_W-1:0] r_row, n_row;
    logic r_kind, n_kind, r_long, n_long, r_dir, n_dir;
    logic [31:0] r_cluster, n_cluster, r_size, n_size;
    logic r_out_valid, n_out_valid;
    logic r_o_kind, n_o_kind, r_o_long, n_o_long, r_o_dir, n_o_dir, r_o_last, n_o_last;
    logic [63:0] r_o_chars, n_o_chars;
    logic [3:0] r_o_cnt, n_o_cnt;
    logic [31:0] r_o_cluster, n_o_cluster, r_o_size, n_o_size;
    logic [3:0] lead;
    logic [CNT_W-1:0] take;
    logic can_emit;
    int k;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.row[SLOT_W-1:0]] <= i_wr.data;
        end
        r_rd_row <= mem[r_row];
        r_rd_ok  <= r_rows[r_row];
    end

    always_comb begin
        n_rows = i_wr.clear ? '0 : r_rows;
        if (i_wr.en) begin
            n_rows[i_wr.row[SLOT_W-1:0]] = 1'b1;
        end
    end

    // merge: count leading characters of the row before the first terminator
    always_comb begin
        lead = 4'(LFN_CHARS);
        for (int i = LFN_CHARS - 1; i >= 0; i--) begin
            if (r_rd_row[i].term) begin
                lead = 4'(i);
            end
        end
        if (!r_rd_ok) begin
            lead = 4'd0;
        end
    end

    assign take     = (r_cnt > CNT_W'(CHARS_PER_RESULT)) ? CNT_W'(CHARS_PER_RESULT) : r_cnt;
    assign can_emit = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_buf       = r_buf;
        n_cnt       = r_cnt;
        n_done      = r_done;
        n_row       = r_row;
        n_kind      = r_kind;
        n_long      = r_long;
        n_dir       = r_dir;
        n_cluster   = r_cluster;
        n_size      = r_size;
        n_out_valid = r_out_valid && !i_out_ready;
        n_o_kind    = r_o_kind;
        n_o_long    = r_o_long;
        n_o_dir     = r_o_dir;
        n_o_last    = r_o_last;
        n_o_chars   = r_o_chars;
        n_o_cnt     = r_o_cnt;
        n_o_cluster = r_o_cluster;
        n_o_size    = r_o_size;
        k           = 0;
        unique case (r_state)
            E_IDLE: begin
                if (i_req.go) begin
                    n_kind    = i_req.end_dir ? KIND_END : KIND_NAME;
                    n_long    = i_req.from_long;
                    n_dir     = i_req.is_dir;
                    n_cluster = i_req.cluster;
                    n_size    = i_req.size;
                    n_row     = '0;
                    if (i_req.end_dir) begin
                        n_cnt   = '0;
                        n_done  = 1'b1;
                        n_state = E_EMIT;
                    end else if (i_req.from_long) begin
                        n_cnt   = '0;
                        n_done  = 1'b0;
                        n_state = E_READ;
                    end else begin
                        for (int j = 0; j < SHORT_LEN; j++) begin
                            n_buf[j] = i_req.text[j];
                        end
                        n_cnt   = CNT_W'(i_req.text_len);
                        n_done  = 1'b1;
                        n_state = E_EMIT;
                    end
                end
            end
            E_READ: begin
                n_state = E_APPEND;
            end
            E_APPEND: begin
                for (int j = 0; j < BUF; j++) begin
                    k = j - int'(r_cnt);
                    if (k >= 0 && k < int'(lead)) begin
                        n_buf[j] = r_rd_row[4'(k)].ch;
                    end
                end
                n_cnt = r_cnt + CNT_W'(lead);
                if (lead != 4'(LFN_CHARS) || r_row == SLOT_W'(MAX_SLOTS - 1)) begin
                    n_done = 1'b1;
                end else begin
                    n_row = r_row + 1'b1;
                end
                n_state = E_EMIT;
            end
            E_EMIT: begin
                if (r_done || r_cnt > CNT_W'(CHARS_PER_RESULT)) begin
                    if (can_emit) begin
                        n_out_valid = 1'b1;
                        n_o_kind    = r_kind;
                        n_o_long    = r_long;
                        n_o_dir     = r_dir;
                        n_o_cluster = r_cluster;
                        n_o_size    = r_size;
                        n_o_cnt     = 4'(take);
                        n_o_last    = r_done && r_cnt <= CNT_W'(CHARS_PER_RESULT);
                        for (int j = 0; j < 8; j++) begin
                            n_o_chars[8*j +: 8] = (j < CHARS_PER_RESULT && j < int'(take)) ?
                                                  r_buf[j] : 8'h00;
                        end
                        for (int j = 0; j < BUF; j++) begin
                            if (j + CHARS_PER_RESULT < BUF) begin
                                n_buf[j] = r_buf[j + CHARS_PER_RESULT];
                            end else begin
                                n_buf[j] = 8'h00;
                            end
                        end
                        n_cnt = r_cnt - take;
                        if (n_o_last) begin
                            n_state = E_IDLE;
                        end
                    end
                end else begin
                    n_state = E_READ;
                end
            end
            default: n_state = E_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= E_IDLE;
            r_rows      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rows      <= n_rows;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf       <= n_buf;
        r_cnt       <= n_cnt;
        r_done      <= n_done;
        r_row       <= n_row;
        r_kind      <= n_kind;
        r_long      <= n_long;
        r_dir       <= n_dir;
        r_cluster   <= n_cluster;
        r_size      <= n_size;
        r_o_kind    <= n_o_kind;
        r_o_long    <= n_o_long;
        r_o_dir     <= n_o_dir;
        r_o_last    <= n_o_last;
        r_o_chars   <= n_o_chars;
        r_o_cnt     <= n_o_cnt;
        r_o_cluster <= n_o_cluster;
        r_o_size    <= n_o_size;
    end

    assign o_busy           = (r_state != E_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_result_kind    = r_o_kind;
    assign o_name_chars     = r_o_chars;
    assign o_char_count     = r_o_cnt;
    assign o_from_long_name = r_o_long;
    assign o_first_cluster  = r_o_cluster;
    assign o_file_size      = r_o_size;
    assign o_is_directory   = r_o_dir;
    assign o_last_of_run    = r_o_last;

endmodule

### hdl/directory_entry_name_assembler.sv
// ----------------------------------------------------------------------------
// directory_entry_name_assembler
// Classifies FAT directory entries, collects long-name rows through 13 lanes
// and emits each file name in chunks.
//
//   channel   direction  handshake                  beat
//   in        input      i_in_valid / o_in_ready    one 32-byte entry + start flag
//   out       output     o_out_valid / i_out_ready  one name chunk or end marker
//
// Each entry is registered and then classified in S_EVAL. A short name is then
// emitted one result at a time. A long name reads one 13-character row at a time
// from the store through its single read port, emitting full results between reads.
// Synchronous active-low reset clears control state; the store needs no clear.
// The next entry is taken once the last result of the current one is loaded.
// ----------------------------------------------------------------------------
module directory_entry_name_assembler
    import dena_pkg::*;
#(
    parameter int NAME_CAPACITY    = 260,
    parameter int MAX_SLOTS        = 20,
    parameter int CHARS_PER_RESULT = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [63:0] i_entry_word0,
    input  logic [63:0] i_entry_word1,
    input  logic [63:0] i_entry_word2,
    input  logic [63:0] i_entry_word3,
    input  logic        i_directory_start,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_result_kind,
    output logic [63:0] o_name_chars,
    output logic [3:0]  o_char_count,
    output logic        o_from_long_name,
    output logic [31:0] o_first_cluster,
    output logic [31:0] o_file_size,
    output logic        o_is_directory,
    output logic        o_last_of_run
);

    localparam logic [31:0] POS_LIMIT = 32'(NAME_CAPACITY - 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EVAL = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic [255:0] r_entry;
    logic [7:0] r_psum, n_psum;
    logic r_name_valid, n_name_valid;
    logic [7:0] r_expected, n_expected;
    logic accept, emit_busy;
    t_row_wr wr;
    t_emit_req req;
    t_row lane_row;

    logic [7:0] first, attr, cks, sum;
    logic [4:0] slot, slot_m1;
    logic slot_ok, live;
    logic [8:0] base;
    logic [3:0] base_len;
    logic [1:0] ext_len;
    logic has_ext;
    logic [7:0] ext [3];
    logic [SHORT_LEN-1:0][7:0] short_text;
    logic [3:0] short_len;
    int m;

    assign o_in_ready = (r_state == S_IDLE) && !emit_busy;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_psum = 8'h00;
        for (int i = 0; i < 6; i++) begin
            n_psum = cks_step(n_psum, i_entry_word0[8*i +: 8]);
        end
    end

    assign first   = r_entry[7:0];
    assign attr    = r_entry[95:88];
    assign cks     = r_entry[111:104];
    assign slot    = first[4:0] & ORDER_SLOT[4:0];
    assign slot_m1 = slot - 5'd1;
    assign slot_ok = (slot != 5'd0) && (32'(slot) <= 32'(MAX_SLOTS));
    assign base    = 9'(slot_m1) * 9'(LFN_CHARS);

    always_comb begin
        sum = r_psum;
        for (int i = 6; i < 11; i++) begin
            sum = cks_step(sum, r_entry[8*i +: 8]);
        end
    end

    for (genvar g = 0; g < LFN_CHARS; g++) begin : g_lane
        localparam int OFS = LFN_OFS[g];
        logic beyond;
        assign beyond = (32'(base) + 32'(g)) >= POS_LIMIT;
        dena_lane u_lane (
            .i_char   (r_entry[8*OFS +: 16]),
            .i_beyond (beyond),
            .o_code   (lane_row[g])
        );
    end

    // 8.3 name: base up to first space, then dot and extension if present
    always_comb begin
        base_len = 4'd8;
        for (int i = 7; i >= 0; i--) begin
            if (r_entry[8*i +: 8] == CHAR_SPACE) begin
                base_len = 4'(i);
            end
        end
        ext_len = 2'd3;
        for (int i = 2; i >= 0; i--) begin
            ext[i] = r_entry[8*(8+i) +: 8];
            if (r_entry[8*(8+i) +: 8] == CHAR_SPACE) begin
                ext_len = 2'(i);
            end
        end
        has_ext = (ext[0] != CHAR_SPACE) || (ext[1] != CHAR_SPACE) || (ext[2] != CHAR_SPACE);
        m = 0;
        for (int j = 0; j < SHORT_LEN; j++) begin
            m = j - int'(base_len) - 1;
            short_text[j] = 8'h00;
            if (j < int'(base_len)) begin
                short_text[j] = (j == 0 && r_entry[7:0] == BYTE_KANJI) ?
                                BYTE_DELETED : r_entry[8*j +: 8];
            end else if (has_ext && j == int'(base_len)) begin
                short_text[j] = CHAR_DOT;
            end else if (has_ext && m >= 0 && m < int'(ext_len)) begin
                short_text[j] = ext[2'(m)];
            end
        end
        short_len = has_ext ? base_len + 4'd1 + 4'(ext_len) : base_len;
    end

    always_comb begin
        n_state      = r_state;
        n_name_valid = r_name_valid;
        n_expected   = r_expected;
        wr.en        = 1'b0;
        wr.clear     = 1'b0;
        wr.row       = slot_m1;
        wr.data      = lane_row;
        req.go       = 1'b0;
        req.end_dir  = 1'b0;
        req.from_long = 1'b0;
        req.text     = short_text;
        req.text_len = short_len;
        req.cluster  = {r_entry[8*21 +: 8], r_entry[8*20 +: 8],
                        r_entry[8*27 +: 8], r_entry[8*26 +: 8]};
        req.size     = r_entry[255:224];
        req.is_dir   = attr[ATTR_DIR_BIT];
        live         = r_name_valid;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_name_valid = r_name_valid && !i_directory_start;
                    n_state      = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_IDLE;
                priority if (first == BYTE_END) begin
                    req.go      = 1'b1;
                    req.end_dir = 1'b1;
                    req.cluster = '0;
                    req.size    = '0;
                    req.is_dir  = 1'b0;
                end else if (first == BYTE_DELETED) begin
                    n_name_valid = 1'b0;
                end else if ((attr & ATTR_LFN_MASK) == ATTR_LFN) begin
                    if ((first & ORDER_FIRST) != 8'h00) begin
                        wr.clear   = 1'b1;
                        n_expected = cks;
                        live       = 1'b1;
                    end
                    if (live) begin
                        if (cks != n_expected || !slot_ok) begin
                            n_name_valid = 1'b0;
                        end else begin
                            n_name_valid = 1'b1;
                            wr.en        = 1'b1;
                        end
                    end
                end else if (attr[ATTR_VOL_BIT]) begin
                    n_name_valid = 1'b0;
                end else begin
                    req.go        = 1'b1;
                    req.from_long = r_name_valid && (sum == r_expected);
                    n_name_valid  = 1'b0;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_name_valid <= 1'b0;
            r_expected   <= 8'h00;
        end else begin
            r_state      <= n_state;
            r_name_valid <= n_name_valid;
            r_expected   <= n_expected;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_entry <= {i_entry_word3, i_entry_word2, i_entry_word1, i_entry_word0};
            r_psum  <= n_psum;
        end
    end

    dena_emit #(
        .MAX_SLOTS        (MAX_SLOTS),
        .CHARS_PER_RESULT (CHARS_PER_RESULT)
    ) u_emit (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_wr             (wr),
        .i_req            (req),
        .o_busy           (emit_busy),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_result_kind    (o_result_kind),
        .o_name_chars     (o_name_chars),
        .o_char_count     (o_char_count),
        .o_from_long_name (o_from_long_name),
        .o_first_cluster  (o_first_cluster),
        .o_file_size      (o_file_size),
        .o_is_directory   (o_is_directory),
        .o_last_of_run    (o_last_of_run)
    );

endmodule

### hdl/dena_checker.sv
// ----------------------------------------------------------------------------
// dena_checker
// Port-level checks for the directory entry name assembler.
// ----------------------------------------------------------------------------
module dena_checker #(
    parameter int CHARS_PER_RESULT = 8
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_result_kind,
    input logic [63:0] o_name_chars,
    input logic [3:0]  o_char_count,
    input logic        o_last_of_run
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_name_chars))
        else $error("output beat changed while stalled");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_char_count <= 4'(CHARS_PER_RESULT))
        else $error("chunk holds too many characters");

    a_end_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind |-> o_last_of_run && o_char_count == 4'd0)
        else $error("end-of-directory beat malformed");

    a_full_chunk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_of_run |-> o_char_count == 4'(CHARS_PER_RESULT))
        else $error("non-final chunk not full");

    a_busy_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_of_run |-> !o_in_ready)
        else $error("entry accepted mid-run");

endmodule

bind directory_entry_name_assembler dena_checker #(
    .CHARS_PER_RESULT (CHARS_PER_RESULT)
) u_dena_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_result_kind (o_result_kind),
    .o_name_chars  (o_name_chars),
    .o_char_count  (o_char_count),
    .o_last_of_run (o_last_of_run)
);

### sim/tb_directory_entry_name_assembler.sv
// ----------------------------------------------------------------------------
// tb_directory_entry_name_assembler
// Drives FAT directory entries into the name assembler and checks each name
// chunk and end marker against an in-bench predictor of long-name assembly,
// checksum matching and 8.3 short-name formatting, under random idling.
// ----------------------------------------------------------------------------
module tb_directory_entry_name_assembler;
    import dena_pkg::*;

    localparam int CAPACITY  = 260;
    localparam int SLOTS     = 20;
    localparam int CHUNK     = 8;
    localparam int CYCLE_CAP = 400000;

    typedef struct packed {
        logic        kind;
        logic [63:0] chars;
        logic [3:0]  count;
        logic        from_long;
        logic [31:0] cluster;
        logic [31:0] size;
        logic        is_dir;
        logic        last;
    } t_chunk;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [63:0] i_entry_word0, i_entry_word1, i_entry_word2, i_entry_word3;
    logic        i_directory_start;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_result_kind;
    logic [63:0] o_name_chars;
    logic [3:0]  o_char_count;
    logic        o_from_long_name;
    logic [31:0] o_first_cluster;
    logic [31:0] o_file_size;
    logic        o_is_directory;
    logic        o_last_of_run;

    directory_entry_name_assembler u_dut (.*);

    // predictor state
    logic [15:0] name_chars_q [CAPACITY];
    logic [7:0]  latched_sum;
    logic        long_valid;
    int          long_len;

    t_chunk pending_chunks[$];
    int     mismatches;
    int     cycle_count;
    int     burst_left;
    bit     stall_on;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        mismatches++;
    endtask

    function automatic logic [7:0] entry_byte(input logic [255:0] e, input int k);
        return e[8*k +: 8];
    endfunction

    function automatic logic [7:0] short_checksum(input logic [255:0] e);
        logic [7:0] s;
        s = 8'h00;
        for (int i = 0; i < 11; i++) s = {s[0], s[7:1]} + entry_byte(e, i);
        return s;
    endfunction

    task automatic drop_long_name();
        long_valid = 1'b0;
        long_len   = 0;
    endtask

    task automatic absorb_long_row(input logic [255:0] e);
        int offs [13] = '{1, 3, 5, 7, 9, 14, 16, 18, 20, 22, 24, 28, 30};
        logic [7:0] order;
        logic [7:0] sum;
        int slot;
        order = entry_byte(e, 0);
        sum   = entry_byte(e, 13);
        if (order & ORDER_FIRST) begin
            for (int i = 0; i < CAPACITY; i++) name_chars_q[i] = CHAR_NONE;
            latched_sum = sum;
            long_valid  = 1'b1;
            long_len    = 0;
        end
        if (!long_valid) return;
        if (latched_sum != sum) begin
            drop_long_name();
            return;
        end
        slot = order & ORDER_SLOT;
        if (slot < 1 || slot > SLOTS) begin
            drop_long_name();
            return;
        end
        for (int i = 0; i < 13; i++)
            if ((slot-1)*13 + i < CAPACITY)
                name_chars_q[(slot-1)*13 + i] = {entry_byte(e, offs[i]+1), entry_byte(e, offs[i])};
        long_len = 0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (name_chars_q[i] == CHAR_NUL || name_chars_q[i] == CHAR_NONE) break;
            long_len++;
        end
    endtask

    task automatic predict_entry(input logic [255:0] e, input logic dstart);
        logic [7:0] txt [CAPACITY + 12];
        int n, nres, pos;
        logic from_long, has_ext;
        logic [7:0] first, attr, b;
        logic [15:0] c;
        t_chunk r;
        n = 0;
        from_long = 1'b0;
        has_ext = 1'b0;
        first = entry_byte(e, 0);
        attr  = entry_byte(e, 11);
        if (dstart) drop_long_name();
        if (first == BYTE_END) begin
            r = '0;
            r.kind = KIND_END;
            r.last = 1'b1;
            pending_chunks.push_back(r);
            return;
        end
        if (first == BYTE_DELETED) begin
            drop_long_name();
            return;
        end
        if ((attr & ATTR_LFN_MASK) == ATTR_LFN) begin
            absorb_long_row(e);
            return;
        end
        if (attr[ATTR_VOL_BIT]) begin
            drop_long_name();
            return;
        end
        if (long_valid && short_checksum(e) == latched_sum) begin
            for (int i = 0; i < long_len && i < CAPACITY - 1; i++) begin
                c = name_chars_q[i];
                if (c == CHAR_NUL || c == CHAR_NONE) break;
                txt[n] = (c < ASCII_LIMIT) ? c[7:0] : CHAR_QMARK;
                n++;
            end
            from_long = 1'b1;
        end else begin
            for (int i = 0; i < 8; i++) begin
                b = entry_byte(e, i);
                if (b == CHAR_SPACE) break;
                txt[n] = (i == 0 && b == BYTE_KANJI) ? BYTE_DELETED : b;
                n++;
            end
            for (int i = 8; i < 11; i++) if (entry_byte(e, i) != CHAR_SPACE) has_ext = 1'b1;
            if (has_ext) begin
                txt[n] = CHAR_DOT;
                n++;
                for (int i = 8; i < 11; i++) begin
                    b = entry_byte(e, i);
                    if (b == CHAR_SPACE) break;
                    txt[n] = b;
                    n++;
                end
            end
        end
        drop_long_name();
        nres = (n + CHUNK - 1) / CHUNK;
        if (nres == 0) nres = 1;
        pos = 0;
        for (int i = 0; i < nres; i++) begin
            r = '0;
            r.kind = KIND_NAME;
            while (r.count < CHUNK && pos < n) begin
                r.chars[8*r.count +: 8] = txt[pos];
                pos++;
                r.count++;
            end
            r.from_long = from_long;
            r.cluster = {entry_byte(e, 21), entry_byte(e, 20), entry_byte(e, 27), entry_byte(e, 26)};
            r.size = {entry_byte(e, 31), entry_byte(e, 30), entry_byte(e, 29), entry_byte(e, 28)};
            r.is_dir = attr[ATTR_DIR_BIT];
            r.last = (i + 1 == nres);
            pending_chunks.push_back(r);
        end
    endtask

    // receiver: stall pattern and checker
    always @(negedge i_clk) begin
        if (stall_on) i_out_ready <= ($urandom_range(0, 3) != 0);
        else          i_out_ready <= 1'b1;
    end

    initial begin
        forever begin
            #4000;
            stall_on = ~stall_on;
        end
    end

    always @(posedge i_clk) begin
        t_chunk want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_chunks.size() == 0) begin
                report("unexpected beat", o_name_chars, 64'h0);
            end else begin
                want = pending_chunks.pop_front();
                if (o_result_kind !== want.kind) report("kind", o_result_kind, want.kind);
                if (o_name_chars !== want.chars) report("chars", o_name_chars, want.chars);
                if (o_char_count !== want.count) report("count", o_char_count, want.count);
                if (o_from_long_name !== want.from_long)
                    report("from_long", o_from_long_name, want.from_long);
                if (o_first_cluster !== want.cluster)
                    report("cluster", o_first_cluster, want.cluster);
                if (o_file_size !== want.size) report("size", o_file_size, want.size);
                if (o_is_directory !== want.is_dir) report("is_dir", o_is_directory, want.is_dir);
                if (o_last_of_run !== want.last) report("last", o_last_of_run, want.last);
            end
        end
    end

    task automatic send_entry(input logic [255:0] e, input logic dstart);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = $urandom_range(0, 8);
        end else begin
            burst_left--;
            @(negedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_entry_word0     <= e[63:0];
        i_entry_word1     <= e[127:64];
        i_entry_word2     <= e[191:128];
        i_entry_word3     <= e[255:192];
        i_directory_start <= dstart;
        while (!o_in_ready) @(negedge i_clk);
        @(posedge i_clk);
        predict_entry(e, dstart);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    function automatic logic [255:0] random_entry();
        return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    endfunction

    // name11 holds the first name character in its top byte
    function automatic logic [255:0] short_entry(input logic [87:0] name11, input logic [7:0] attr);
        logic [255:0] e;
        e = random_entry();
        for (int i = 0; i < 11; i++) e[8*i +: 8] = name11[8*(10-i) +: 8];
        e[95:88] = attr;
        return e;
    endfunction

    function automatic logic [255:0] long_row(input logic [7:0] order, input logic [7:0] sum,
                                              input bit ascii, input int stop_at);
        int offs [13] = '{1, 3, 5, 7, 9, 14, 16, 18, 20, 22, 24, 28, 30};
        logic [255:0] e;
        logic [15:0] c;
        e = random_entry();
        e[7:0]     = order;
        e[95:88]   = ATTR_LFN;
        e[111:104] = sum;
        for (int i = 0; i < 13; i++) begin
            c = ascii ? 16'($urandom_range(8'h21, 8'h7E)) : 16'($urandom);
            if (c == CHAR_NUL || c == CHAR_NONE) c = 16'h0041;
            if (i == stop_at) c = CHAR_NUL;
            if (i > stop_at) c = CHAR_NONE;
            e[8*offs[i] +: 16] = c;
        end
        return e;
    endfunction

    task automatic send_long_file(input int rows, input bit ascii, input int corrupt);
        logic [255:0] sfn;
        logic [7:0] sum, ord;
        int stop;
        sfn = short_entry(88'({$urandom, $urandom, $urandom}),
                          8'($urandom_range(0, 1) ? 8'h10 : 8'h20));
        if (sfn[7:0] == BYTE_END || sfn[7:0] == BYTE_DELETED) sfn[7:0] = 8'h41;
        sum = short_checksum(sfn);
        stop = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 12) : 13;
        for (int r = rows; r >= 1; r--) begin
            ord = 8'(r);
            if (r == rows) ord = ord | ORDER_FIRST;
            if (corrupt == 1 && r == 1) send_entry(long_row(ord, sum ^ 8'h01, ascii, 13), 1'b0);
            else if (corrupt == 2 && r == 1)
                send_entry(long_row(8'h00 | 8'($urandom_range(21, 31)), sum, ascii, 13), 1'b0);
            else send_entry(long_row(ord, sum, ascii, r == rows ? stop : 13), 1'b0);
        end
        if (corrupt == 3) sfn[0] = ~sfn[0];
        send_entry(sfn, 1'b0);
    endtask

    task automatic wait_drained();
        while (pending_chunks.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic test_short_names();
        send_entry(short_entry({"README  ", "TXT"}, 8'h20), 1'b1);
        send_entry(short_entry({"NOEXT   ", "   "}, 8'h10), 1'b0);
        send_entry(short_entry({8'h05, "KANJI  ", "C  "}, 8'h00), 1'b0);
        send_entry(short_entry({"        ", "   "}, 8'h00), 1'b0);
        send_entry(short_entry({"ABCDEFGH", "A B"}, 8'hE7), 1'b0);
        send_entry(short_entry({88{1'b1}}, 8'hFF), 1'b0);
        send_entry(short_entry({"DELETED ", "XYZ"} | {8'hE5, 80'h0}, 8'h20), 1'b0);
        send_entry(short_entry({"VOLUME  ", "LBL"}, 8'h08), 1'b0);
        send_entry({256{1'b1}} & ~256'hFF, 1'b1);
        send_entry({256{1'b0}}, 1'b0);
        send_entry({256{1'b1}} & ~(256'h08 << 88), 1'b0);
    endtask

    task automatic test_long_names();
        send_long_file(1, 1'b1, 0);
        send_long_file(2, 1'b0, 0);
        send_long_file(SLOTS, 1'b1, 0);
        send_long_file(3, 1'b1, 1);
        send_long_file(2, 1'b1, 2);
        send_long_file(2, 1'b1, 3);
        send_entry(long_row(8'h02, 8'h00, 1'b1, 13), 1'b0);
        send_entry(long_row(ORDER_FIRST | 8'h01, 8'h00, 1'b1, 13), 1'b1);
    endtask

    task automatic test_random_mix();
        logic [255:0] e;
        for (int i = 0; i < 20; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: send_long_file($urandom_range(1, 4), $urandom_range(0, 1),
                                           ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
                4: send_long_file($urandom_range(15, SLOTS), 1'b1, 0);
                5: send_entry(random_entry(), $urandom_range(0, 1));
                6: begin
                    e = random_entry();
                    e[7:0] = BYTE_END;
                    send_entry(e, $urandom_range(0, 1));
                end
                default: send_entry(short_entry(88'({$urandom, $urandom, $urandom}),
                                                8'($urandom)), $urandom_range(0, 1));
            endcase
            if (i == 10) wait_drained();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_entry_word0 = '0;
        i_entry_word1 = '0;
        i_entry_word2 = '0;
        i_entry_word3 = '0;
        i_directory_start = 1'b0;
        i_out_ready = 1'b0;
        mismatches = 0;
        cycle_count = 0;
        burst_left = 0;
        stall_on = 1'b0;
        latched_sum = '0;
        long_valid = 1'b0;
        long_len = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_short_names();
        test_long_names();
        wait_drained();
        test_random_mix();
        wait_drained();
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
